// File: design/ajb_pkg.sv
package ajb_pkg;

    // Width of the item buses, in bits
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    // Item kinds on the input side
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kinds on the output side
    typedef enum logic [1:0] {
        PS_ACCEPT = 2'd0,
        PS_EVICT  = 2'd1,
        PS_REJECT = 2'd2,
        PS_TICK   = 2'd3
    } t_push_status;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_TARGET = 3'd0;
    localparam logic [2:0] CFG_MIN_TARGET   = 3'd1;
    localparam logic [2:0] CFG_MAX_TARGET   = 3'd2;
    localparam logic [2:0] CFG_STARVE_LIMIT = 3'd3;
    localparam logic [2:0] CFG_SHRINK_AFTER = 3'd4;

    // Reset values of the configuration registers
    localparam logic [3:0] RST_START_TARGET = 4'd2;
    localparam logic [3:0] RST_MIN_TARGET   = 4'd2;
    localparam logic [3:0] RST_MAX_TARGET   = 4'd10;
    localparam logic [7:0] RST_STARVE_LIMIT = 8'd10;
    localparam logic [7:0] RST_SHRINK_AFTER = 8'd250;

    localparam logic [3:0] TARGET_CEIL = 4'd15;
    localparam logic [7:0] RUN_SAT     = 8'd255;

    // One queued frame descriptor
    typedef struct packed {
        logic [15:0]        seq;
        logic [7:0]         handle;
        logic [8:0]         len;
        logic               occ;
        logic [15:0]        gain;
        logic signed [15:0] pan;
    } t_entry;

    // Operation broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_INS_FULL,
        CELL_POP
    } t_cell_op;

endpackage

// File: design/ajb_cell.sv
module ajb_cell (
    input  logic              i_clk,
    input  ajb_pkg::t_cell_op i_op,
    input  ajb_pkg::t_entry   i_new,      // descriptor being inserted
    input  ajb_pkg::t_entry   i_left,     // lower neighbor (new entry for the head cell)
    input  logic              i_lt_left,  // lower neighbor sorts below the new entry
    input  ajb_pkg::t_entry   i_right,    // upper neighbor
    input  logic              i_lt_right, // upper neighbor sorts below the new entry
    input  logic              i_occ,      // this cell holds a queued entry
    output ajb_pkg::t_entry   o_ent,
    output logic              o_lt
);

    ajb_pkg::t_entry r_ent;
    ajb_pkg::t_entry n_ent;

    // Held entry sorts strictly below the new one, so it stays in front of it
    assign o_lt  = i_occ && (r_ent.seq < i_new.seq);
    assign o_ent = r_ent;

    // Choose this cell's next entry from itself, a neighbor or the new item
    always_comb begin
        n_ent = r_ent;
        unique case (i_op)
            ajb_pkg::CELL_HOLD: begin
                n_ent = r_ent;
            end
            ajb_pkg::CELL_INS: begin
                if (o_lt) begin
                    n_ent = r_ent;
                end else if (i_lt_left) begin
                    n_ent = i_new;
                end else begin
                    n_ent = i_left;
                end
            end
            ajb_pkg::CELL_INS_FULL: begin
                if (i_lt_right) begin
                    n_ent = i_right;
                end else if (o_lt) begin
                    n_ent = i_new;
                end else begin
                    n_ent = r_ent;
                end
            end
            ajb_pkg::CELL_POP: begin
                n_ent = i_right;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

// File: design/adaptive_jitter_buffer.sv
// Channel  | Direction | Handshake                 | Contents
// s        | in        | i_s_tvalid / o_s_tready   | push descriptor or playout tick
// m        | out       | o_m_tvalid / i_m_tready   | push status, popped frame, status
// cfg      | in        | i_cfg_valid / o_cfg_ready | register index and write data
//
// One item per cycle while the output side keeps up: the whole row of cells shifts or
// inserts at once, and each item's result appears in the output register in the cycle after acceptance.
// The input stalls only while a result is held and the output side is not ready.
// Reset (synchronous, active low) empties the queue, stops playout and restores
// the register defaults; queued entries themselves are not cleared.
module adaptive_jitter_buffer #(
    parameter int QUEUE_DEPTH     = 16,
    parameter int MAX_FRAME_BYTES = 256,
    parameter int HANDLE_BITS     = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // seq_num[15:0], frame_handle[23:16], frame_len[39:24], gain_word[55:40],
    // pan_word[71:56], occluded[72], zero fill above
    input  logic [ajb_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // cmd[0]
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // frame_valid[0], out_seq[16:1], out_handle[24:17], out_len[33:25],
    // out_gain[49:34], out_pan[65:50], out_occluded[66], is_playing[67],
    // cur_target[71:68], fill_level[76:72], zero fill above
    output logic [ajb_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // push_status[1:0]
    output logic [1:0]                       o_m_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [2:0]                       i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (FW > 4) ? FW : 4;
    localparam logic [7:0] HMASK =
        (HANDLE_BITS >= 8) ? 8'hFF : 8'((1 << HANDLE_BITS) - 1);
    localparam logic [16:0] LEN_MAX = 17'(MAX_FRAME_BYTES);

    // Configuration registers
    logic [3:0] r_min_target, r_max_target;
    logic [7:0] r_starve_limit, r_shrink_after;

    // Control state
    logic [FW-1:0] r_fill, n_fill;
    logic          r_playing, n_playing;
    logic [3:0]    r_target, n_target;
    logic [7:0]    r_healthy, n_healthy;
    logic [7:0]    r_starve, n_starve;

    // Output register
    logic                          r_out_valid;
    logic [1:0]                    r_out_user, n_out_user;
    logic [ajb_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic              w_accept;
    logic              w_cfg_wr;
    ajb_pkg::t_entry   w_new;
    ajb_pkg::t_cell_op w_op;
    ajb_pkg::t_entry   w_ent [QUEUE_DEPTH];
    logic              w_lt  [QUEUE_DEPTH];
    logic              w_occ [QUEUE_DEPTH];
    logic              w_full;
    logic              w_too_long;
    logic              w_play_now;
    logic [7:0]        w_h_inc, w_s_inc;
    logic              w_pop_valid;
    logic [FW+4:0]     w_fill_ext;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // Unpack the incoming descriptor
    always_comb begin
        w_new.seq    = i_s_tdata[15:0];
        w_new.handle = i_s_tdata[23:16] & HMASK;
        w_new.len    = i_s_tdata[32:24];
        w_new.gain   = i_s_tdata[55:40];
        w_new.pan    = i_s_tdata[71:56];
        w_new.occ    = i_s_tdata[72];
    end

    assign w_too_long = {1'b0, i_s_tdata[39:24]} > LEN_MAX;
    assign w_full     = (r_fill == FW'(QUEUE_DEPTH));
    assign w_play_now = r_playing || (CW'(r_fill) >= CW'(r_target));
    assign w_h_inc    = (r_healthy == ajb_pkg::RUN_SAT) ? r_healthy : r_healthy + 8'd1;
    assign w_s_inc    = (r_starve == ajb_pkg::RUN_SAT) ? r_starve : r_starve + 8'd1;
    assign w_pop_valid = w_play_now && (r_fill != '0);

    // Row of cells; cell 0 is the head of the queue
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign w_occ[g] = (r_fill > FW'(g));
        if (g == 0) begin : g_head
            ajb_cell u_cell (
                .i_clk      (i_clk),
                .i_op       (w_op),
                .i_new      (w_new),
                .i_left     (w_new),
                .i_lt_left  (1'b0),
                .i_right    (w_ent[(QUEUE_DEPTH > 1) ? 1 : 0]),
                .i_lt_right ((QUEUE_DEPTH > 1) ? w_lt[(QUEUE_DEPTH > 1) ? 1 : 0] : 1'b0),
                .i_occ      (w_occ[g]),
                .o_ent      (w_ent[g]),
                .o_lt       (w_lt[g])
            );
        end else if (g == QUEUE_DEPTH - 1) begin : g_tail
            ajb_cell u_cell (
                .i_clk      (i_clk),
                .i_op       (w_op),
                .i_new      (w_new),
                .i_left     (w_ent[g-1]),
                .i_lt_left  (w_lt[g-1]),
                .i_right    (w_ent[g]),
                .i_lt_right (1'b0),
                .i_occ      (w_occ[g]),
                .o_ent      (w_ent[g]),
                .o_lt       (w_lt[g])
            );
        end else begin : g_mid
            ajb_cell u_cell (
                .i_clk      (i_clk),
                .i_op       (w_op),
                .i_new      (w_new),
                .i_left     (w_ent[g-1]),
                .i_lt_left  (w_lt[g-1]),
                .i_right    (w_ent[g+1]),
                .i_lt_right (w_lt[g+1]),
                .i_occ      (w_occ[g]),
                .o_ent      (w_ent[g]),
                .o_lt       (w_lt[g])
            );
        end
    end

    // Decide the row operation, the control state and the result
    always_comb begin
        w_op       = ajb_pkg::CELL_HOLD;
        n_fill     = r_fill;
        n_playing  = r_playing;
        n_target   = r_target;
        n_healthy  = r_healthy;
        n_starve   = r_starve;
        n_out_user = r_out_user;
        n_out_data = r_out_data;

        if (w_accept) begin
            if (i_s_tuser == ajb_pkg::CMD_PUSH) begin
                priority if (w_too_long) begin
                    n_out_user = ajb_pkg::PS_REJECT;
                end else if (w_full) begin
                    w_op       = ajb_pkg::CELL_INS_FULL;
                    n_out_user = ajb_pkg::PS_EVICT;
                end else begin
                    w_op       = ajb_pkg::CELL_INS;
                    n_fill     = r_fill + FW'(1);
                    n_out_user = ajb_pkg::PS_ACCEPT;
                end
            end else begin
                n_out_user = ajb_pkg::PS_TICK;
                n_playing  = w_play_now;
                if (w_play_now) begin
                    if (w_pop_valid) begin
                        // Pop the head and track the healthy run
                        w_op     = ajb_pkg::CELL_POP;
                        n_fill   = r_fill - FW'(1);
                        n_starve = '0;
                        if (CW'(r_fill) >= CW'(r_target)) begin
                            n_healthy = w_h_inc;
                            if ((w_h_inc >= r_shrink_after) && (r_target > r_min_target)) begin
                                n_target  = r_target - 4'd1;
                                n_healthy = '0;
                            end
                        end else begin
                            n_healthy = '0;
                        end
                    end else begin
                        // Underrun: grow the target and count the starve
                        if ((r_target < r_max_target) && (r_target < ajb_pkg::TARGET_CEIL)) begin
                            n_target = r_target + 4'd1;
                        end
                        n_healthy = '0;
                        n_starve  = w_s_inc;
                        if (w_s_inc >= r_starve_limit) begin
                            n_playing = 1'b0;
                            n_starve  = '0;
                        end
                    end
                end
            end

            w_fill_ext = (FW + 5)'(n_fill);
            n_out_data = '0;
            if (w_pop_valid && (i_s_tuser == ajb_pkg::CMD_TICK)) begin
                n_out_data[0]     = 1'b1;
                n_out_data[16:1]  = w_ent[0].seq;
                n_out_data[24:17] = w_ent[0].handle;
                n_out_data[33:25] = w_ent[0].len;
                n_out_data[49:34] = w_ent[0].gain;
                n_out_data[65:50] = w_ent[0].pan;
                n_out_data[66]    = w_ent[0].occ;
            end
            n_out_data[67]    = n_playing;
            n_out_data[71:68] = n_target;
            n_out_data[76:72] = w_fill_ext[4:0];
        end else begin
            w_fill_ext = '0;
        end

        // A start_target write loads the live target directly, overriding any update from the item
        if (w_cfg_wr && (i_cfg_index == ajb_pkg::CFG_START_TARGET)) begin
            n_target = i_cfg_data[3:0];
        end
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill         <= '0;
            r_playing      <= 1'b0;
            r_target       <= ajb_pkg::RST_START_TARGET;
            r_healthy      <= '0;
            r_starve       <= '0;
            r_min_target   <= ajb_pkg::RST_MIN_TARGET;
            r_max_target   <= ajb_pkg::RST_MAX_TARGET;
            r_starve_limit <= ajb_pkg::RST_STARVE_LIMIT;
            r_shrink_after <= ajb_pkg::RST_SHRINK_AFTER;
            r_out_valid    <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_playing <= n_playing;
            r_target  <= n_target;
            r_healthy <= n_healthy;
            r_starve  <= n_starve;
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    ajb_pkg::CFG_MIN_TARGET:   r_min_target   <= i_cfg_data[3:0];
                    ajb_pkg::CFG_MAX_TARGET:   r_max_target   <= i_cfg_data[3:0];
                    ajb_pkg::CFG_STARVE_LIMIT: r_starve_limit <= i_cfg_data;
                    ajb_pkg::CFG_SHRINK_AFTER: r_shrink_after <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_user <= n_out_user;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // Fill never passes the row length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_fill) <= CW'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    // Head pair of the row stays in ascending order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill >= FW'(2)) && (QUEUE_DEPTH > 1) |->
            w_ent[0].seq <= w_ent[(QUEUE_DEPTH > 1) ? 1 : 0].seq)
        else $error("queue head out of order");

    // An insert into a queue with room grows the fill by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_s_tuser == ajb_pkg::CMD_PUSH) && !w_too_long && !w_full |=>
            r_fill == $past(r_fill) + FW'(1))
        else $error("insert did not grow fill");

    // Only a tick result can carry a popped frame
    a_pop_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[0] |-> r_out_user == ajb_pkg::PS_TICK)
        else $error("popped frame on a push result");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import ajb_pkg::*;

    localparam int JB_DEPTH     = 16;
    localparam int MAX_LEN      = 256;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG     = 2000;
    localparam int PHASE_ITEMS  = 170;
    localparam int DIR_ROWS     = 21;
    localparam int PHASES       = 6;

    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} t_rx_mode;
    typedef enum {PR_NONE, PR_HOLD, PR_PAUSE} t_pressure;

    // One result item, split into its fields
    typedef struct packed {
        t_push_status status;
        logic         valid;
        logic [15:0]  seq;
        logic [7:0]   handle;
        logic [8:0]   len;
        logic [15:0]  gain;
        logic [15:0]  pan;
        logic         occ;
        logic         playing;
        logic [3:0]   target;
        logic [4:0]   fill;
    } t_result;

    // Directed row: stimulus plus an optional hand-written status
    typedef struct {
        logic         cmd;
        logic [15:0]  seq;
        logic [7:0]   handle;
        logic [15:0]  len;
        logic [15:0]  gain;
        logic [15:0]  pan;
        logic         occ;
        bit           typed;
        t_push_status x_status;
        logic         x_playing;
        logic [3:0]   x_target;
        logic [4:0]   x_fill;
    } t_dir_row;

    // Register setting and traffic shape of one random phase
    typedef struct {
        int        start;
        int        lo;
        int        hi;
        int        starve;
        int        shrink;
        int        p_push;
        t_rx_mode  rx;
        bit        gaps;
        t_pressure press;
        int        seq0;
    } t_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [2:0]            i_cfg_index = '0;
    logic [7:0]            i_cfg_data = '0;

    adaptive_jitter_buffer dut (.*);

    // Predicted buffer contents and control state
    t_entry   jq[$];
    bit       m_playing = 1'b0;
    int       m_target  = RST_START_TARGET;
    int       m_healthy = 0;
    int       m_starve  = 0;
    int       r_min     = RST_MIN_TARGET;
    int       r_max     = RST_MAX_TARGET;
    int       r_starve  = RST_STARVE_LIMIT;
    int       r_shrink  = RST_SHRINK_AFTER;

    t_result  due_results[$];
    t_result  want;
    t_result  got;
    t_result  typed_res;
    bit       typed_on = 1'b0;

    t_rx_mode rx_mode = RX_MOSTLY;
    bit       tx_gaps = 1'b1;
    bit       hold_req = 1'b0;
    int       hold_left = 0;
    int       rx_count = 0;
    int       burst_left = 0;
    logic [15:0] seq_next = '0;

    int errors = 0;
    int idle_cycles = 0;
    int n_items = 0, n_push = 0, n_tick = 0, n_pop = 0, n_conceal = 0;
    int n_evict = 0, n_reject = 0, n_results = 0;

    t_dir_row dir_tab [DIR_ROWS];
    t_phase   phases [PHASES];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Work out the result of one accepted item and advance the predicted state
    function automatic t_result jitter_step(input logic cmd, input logic [79:0] d);
        t_result r;
        t_entry  e;
        int      pos;
        r = '0;
        if (cmd == CMD_PUSH) begin
            if (d[39:24] > MAX_LEN) begin
                r.status = PS_REJECT;
            end else begin
                e.seq    = d[15:0];
                e.handle = d[23:16];
                e.len    = d[32:24];
                e.gain   = d[55:40];
                e.pan    = d[71:56];
                e.occ    = d[72];
                // equal numbers go ahead of the entries already held
                pos = 0;
                while (pos < jq.size() && jq[pos].seq < e.seq) pos++;
                jq.insert(pos, e);
                r.status = PS_ACCEPT;
                if (jq.size() > JB_DEPTH) begin
                    jq.delete(0);
                    r.status = PS_EVICT;
                end
            end
        end else begin
            r.status = PS_TICK;
            if (!m_playing && jq.size() >= m_target) m_playing = 1'b1;
            if (m_playing) begin
                if (jq.size() > 0) begin
                    e = jq[0];
                    jq.delete(0);
                    r.valid  = 1'b1;
                    r.seq    = e.seq;
                    r.handle = e.handle;
                    r.len    = e.len;
                    r.gain   = e.gain;
                    r.pan    = e.pan;
                    r.occ    = e.occ;
                    m_starve = 0;
                    if (jq.size() + 1 >= m_target) begin
                        if (m_healthy < RUN_SAT) m_healthy++;
                        if (m_healthy >= r_shrink && m_target > r_min) begin
                            m_target--;
                            m_healthy = 0;
                        end
                    end else begin
                        m_healthy = 0;
                    end
                end else begin
                    // underrun: grow the target, stop play after a long starve
                    if (m_target < r_max && m_target < TARGET_CEIL) m_target++;
                    m_healthy = 0;
                    if (m_starve < RUN_SAT) m_starve++;
                    if (m_starve >= r_starve) begin
                        m_playing = 1'b0;
                        m_starve  = 0;
                    end
                end
            end
        end
        r.playing = m_playing;
        r.target  = m_target[3:0];
        r.fill    = 5'(jq.size());
        return r;
    endfunction

    function automatic void cmp(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, actual %0h", nm, e, a);
            errors++;
        end
    endfunction

    // Check results, track accepted items and register writes, watch for hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    $error("result item with no item pending");
                    errors++;
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    cmp("push_status",  want.status,  o_m_tuser);
                    cmp("frame_valid",  want.valid,   o_m_tdata[0]);
                    cmp("out_seq",      want.seq,     o_m_tdata[16:1]);
                    cmp("out_handle",   want.handle,  o_m_tdata[24:17]);
                    cmp("out_len",      want.len,     o_m_tdata[33:25]);
                    cmp("out_gain",     want.gain,    o_m_tdata[49:34]);
                    cmp("out_pan",      want.pan,     o_m_tdata[65:50]);
                    cmp("out_occluded", want.occ,     o_m_tdata[66]);
                    cmp("is_playing",   want.playing, o_m_tdata[67]);
                    cmp("cur_target",   want.target,  o_m_tdata[71:68]);
                    cmp("fill_level",   want.fill,    o_m_tdata[76:72]);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                got = jitter_step(i_s_tuser, i_s_tdata);
                n_items++;
                if (i_s_tuser == CMD_PUSH) n_push++;
                else n_tick++;
                if (got.status == PS_EVICT) n_evict++;
                if (got.status == PS_REJECT) n_reject++;
                if (got.status == PS_TICK && got.valid) n_pop++;
                if (got.status == PS_TICK && !got.valid) n_conceal++;
                due_results.insert(due_results.size(), typed_on ? typed_res : got);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_TARGET: m_target = i_cfg_data[3:0];
                    CFG_MIN_TARGET:   r_min    = i_cfg_data[3:0];
                    CFG_MAX_TARGET:   r_max    = i_cfg_data[3:0];
                    CFG_STARVE_LIMIT: r_starve = i_cfg_data;
                    CFG_SHRINK_AFTER: r_shrink = i_cfg_data;
                    default: ;
                endcase
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: long hold-off on request, otherwise the phase's stall pattern
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        rx_count++;
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_m_tready <= 1'b1;
                RX_MOSTLY:  i_m_tready <= ($urandom_range(0, 99) < 75);
                RX_SPARSE:  i_m_tready <= ($urandom_range(0, 99) < 30);
                RX_PATTERN: i_m_tready <= ((rx_count % 7) < 3);
                default:    i_m_tready <= 1'b1;
            endcase
        end
    end

    // Offer one item and hold it until the block takes it
    task automatic put_item(input logic cmd, input logic [79:0] d);
        i_s_tuser  <= cmd;
        i_s_tdata  <= d;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // End a burst now and then with a random gap
    task automatic tx_gap();
        if (tx_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 20);
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    endtask

    // Stop sending and wait for every pending result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int val);
        i_cfg_index <= idx;
        i_cfg_data  <= val[7:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Voice-stream traffic: mostly in order, with loss, late, duplicate and junk numbers
    task automatic make_item(input int p_push, output logic cmd, output logic [79:0] d);
        int          r;
        logic [15:0] s;
        logic [15:0] len;
        d = 80'({$urandom, $urandom, $urandom});
        d[79:73] = '0;
        cmd = ($urandom_range(0, 99) < p_push) ? CMD_PUSH : CMD_TICK;
        if (cmd == CMD_PUSH) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                s = seq_next;
                seq_next++;
            end else if (r < 80) begin
                seq_next = seq_next + 16'($urandom_range(1, 3));
                s = seq_next;
                seq_next++;
            end else if (r < 88) begin
                s = seq_next - 16'($urandom_range(1, 20));
            end else if (r < 93) begin
                s = seq_next - 16'd1;
            end else begin
                s = 16'($urandom_range(0, 65535));
            end
            r = $urandom_range(0, 99);
            if (r < 85) len = 16'($urandom_range(0, MAX_LEN));
            else if (r < 90) len = 16'(MAX_LEN);
            else len = 16'($urandom_range(MAX_LEN + 1, 65535));
            d[15:0]  = s;
            d[39:24] = len;
        end
    endtask

    initial begin
        logic        cmd;
        logic [79:0] d;
        t_phase      ph;

        dir_tab = '{
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b1, PS_TICK,   1'b0, 4'd2, 5'd0},
            '{CMD_PUSH, 16'd100,  8'h01, 16'd257,  16'h1111, 16'h0001, 1'b0,
              1'b1, PS_REJECT, 1'b0, 4'd2, 5'd0},
            '{CMD_PUSH, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              1'b1, PS_REJECT, 1'b0, 4'd2, 5'd0},
            '{CMD_PUSH, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b1, PS_ACCEPT, 1'b0, 4'd2, 5'd1},
            '{CMD_PUSH, 16'hFFFF, 8'hFF, 16'd256,  16'hFFFF, 16'h8000, 1'b1,
              1'b1, PS_ACCEPT, 1'b0, 4'd2, 5'd2},
            '{CMD_PUSH, 16'd500,  8'hAA, 16'd100,  16'h5555, 16'h7FFF, 1'b0,
              1'b0, PS_ACCEPT, 1'b0, 4'd0, 5'd0},
            '{CMD_PUSH, 16'd500,  8'h55, 16'd37,   16'hAAAA, 16'h1234, 1'b1,
              1'b0, PS_ACCEPT, 1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_PUSH, 16'd7,    8'h3C, 16'd200,  16'h0F0F, 16'hF0F0, 1'b0,
              1'b0, PS_ACCEPT, 1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_PUSH, 16'd200,  8'hC3, 16'd256,  16'h8001, 16'h0000, 1'b1,
              1'b0, PS_ACCEPT, 1'b0, 4'd0, 5'd0},
            '{CMD_PUSH, 16'd3,    8'h81, 16'd1,    16'h7FFE, 16'h8001, 1'b1,
              1'b0, PS_ACCEPT, 1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0},
            '{CMD_TICK, 16'd0,    8'h00, 16'd0,    16'h0000, 16'h0000, 1'b0,
              1'b0, PS_TICK,   1'b0, 4'd0, 5'd0}
        };

        // reset values first, then low and high extremes, odd zero settings, mixes
        phases = '{
            '{2,  2,  10, 10,  250, 50, RX_MOSTLY,  1'b1, PR_NONE,  1000},
            '{1,  1,  15, 1,   1,   45, RX_PATTERN, 1'b1, PR_NONE,  65500},
            '{15, 15, 15, 255, 255, 60, RX_SPARSE,  1'b1, PR_NONE,  20000},
            '{4,  0,  3,  0,   0,   50, RX_ALWAYS,  1'b0, PR_NONE,  300},
            '{5,  3,  8,  4,   6,   35, RX_MOSTLY,  1'b1, PR_HOLD,  40000},
            '{2,  2,  12, 20,  10,  70, RX_MOSTLY,  1'b1, PR_PAUSE, 65000}
        };

        // Hold reset low, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows
        foreach (dir_tab[k]) begin
            d = '0;
            d[15:0]  = dir_tab[k].seq;
            d[23:16] = dir_tab[k].handle;
            d[39:24] = dir_tab[k].len;
            d[55:40] = dir_tab[k].gain;
            d[71:56] = dir_tab[k].pan;
            d[72]    = dir_tab[k].occ;
            typed_res         = '0;
            typed_res.status  = dir_tab[k].x_status;
            typed_res.playing = dir_tab[k].x_playing;
            typed_res.target  = dir_tab[k].x_target;
            typed_res.fill    = dir_tab[k].x_fill;
            typed_on = dir_tab[k].typed;
            put_item(dir_tab[k].cmd, d);
            tx_gap();
        end
        typed_on = 1'b0;

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            ph = phases[p];
            if (p > 0) begin
                drain();
                cfg_write(CFG_START_TARGET, ph.start);
                cfg_write(CFG_MIN_TARGET,   ph.lo);
                cfg_write(CFG_MAX_TARGET,   ph.hi);
                cfg_write(CFG_STARVE_LIMIT, ph.starve);
                cfg_write(CFG_SHRINK_AFTER, ph.shrink);
            end
            rx_mode  = ph.rx;
            tx_gaps  = ph.gaps;
            seq_next = 16'(ph.seq0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 60 && ph.press == PR_HOLD) hold_req = 1'b1;
                if (n == 90 && ph.press == PR_PAUSE) drain();
                make_item(ph.p_push, cmd, d);
                put_item(cmd, d);
                tx_gap();
            end
        end

        // Wait for the last results, then idle before reporting
        i_s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);

        $display("Covered %0d items (%0d pushes, %0d ticks): %0d pops, %0d concealed ticks",
                 n_items, n_push, n_tick, n_pop, n_conceal);
        $display("%0d evictions, %0d rejects, %0d results checked, %0d mismatches",
                 n_evict, n_reject, n_results, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
